>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, held off while in reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ppu_pkg.sv
// Package: constants, register codes and lane control type of the unwrap block.
`timescale 1ns / 1ps

package ppu_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int OFF_BITS       = 48;
	localparam int PERIOD_BITS    = 31;
	localparam int WIDE_BITS      = OFF_BITS + 4;
	localparam int NUM_AXES       = 3;
	localparam int REG_IDX_BITS   = 2;

	localparam logic [REG_IDX_BITS-1:0] REG_PERIOD_X = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_PERIOD_Y = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_PERIOD_Z = 2'd2;

	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 31'd65536;

	localparam logic signed [WIDE_BITS-1:0] OFF_HI =
		(WIDE_BITS'(1) <<< (OFF_BITS - 1)) - WIDE_BITS'(1);
	localparam logic signed [WIDE_BITS-1:0] OFF_LO = -OFF_HI - WIDE_BITS'(1);

	typedef struct packed {
		logic fire;       // item transferred this cycle
		logic start;      // item opens a new line
		logic have_prev;  // a point of the current line was already emitted
	} lane_ctl_t;

endpackage

>>> sv/ppu_in_if.sv
// Input channel: one wrapped point per transfer.
`timescale 1ns / 1ps

interface ppu_in_if import ppu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic signed [COORD_BITS-1:0] coord_z;
	logic                         line_start;

	modport source (output valid, coord_x, coord_y, coord_z, line_start, input ready);
	modport sink   (input valid, coord_x, coord_y, coord_z, line_start, output ready);
endinterface

>>> sv/ppu_out_if.sv
// Output channel: one unwrapped point per transfer.
`timescale 1ns / 1ps

interface ppu_out_if import ppu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] unwrapped_x;
	logic signed [COORD_BITS-1:0] unwrapped_y;
	logic signed [COORD_BITS-1:0] unwrapped_z;
	logic                         saturated;

	modport source (output valid, unwrapped_x, unwrapped_y, unwrapped_z, saturated,
		input ready);
	modport sink   (input valid, unwrapped_x, unwrapped_y, unwrapped_z, saturated,
		output ready);
endinterface

>>> sv/ppu_lane.sv
// One axis lane: applies the wrap offset, tests the jump and keeps the lane state.
`timescale 1ns / 1ps

module ppu_lane import ppu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lane_ctl_t                    ctl,
	input  logic signed [COORD_BITS-1:0] coord,
	input  logic [PERIOD_BITS-1:0]       period,
	output logic signed [COORD_BITS-1:0] result,
	output logic                         sat
);

	localparam logic signed [WIDE_BITS-1:0] C_HI =
		(WIDE_BITS'(1) <<< (COORD_BITS - 1)) - WIDE_BITS'(1);
	localparam logic signed [WIDE_BITS-1:0] C_LO = -C_HI - WIDE_BITS'(1);

	logic signed [OFF_BITS-1:0]   off_q;
	logic signed [COORD_BITS-1:0] prev_q;

	logic signed [WIDE_BITS-1:0] c_w, off_w, prev_w, per_w, p_w, d2, off_n, p_n;
	logic signed [OFF_BITS-1:0]  off_c;
	logic                        hp, up, dn;

	always_comb begin
		hp     = ctl.have_prev && !ctl.start;
		c_w    = {{(WIDE_BITS-COORD_BITS){coord[COORD_BITS-1]}}, coord};
		off_w  = ctl.start ? '0 : {{(WIDE_BITS-OFF_BITS){off_q[OFF_BITS-1]}}, off_q};
		prev_w = {{(WIDE_BITS-COORD_BITS){prev_q[COORD_BITS-1]}}, prev_q};
		per_w  = {{(WIDE_BITS-PERIOD_BITS){1'b0}}, period};
		p_w    = c_w + off_w;
		d2     = (p_w - prev_w) <<< 1;
		up     = hp && (d2 > per_w);
		dn     = hp && !up && (d2 < -per_w);
		if (up) begin
			off_n = off_w - per_w;
			p_n   = p_w - per_w;
		end else if (dn) begin
			off_n = off_w + per_w;
			p_n   = p_w + per_w;
		end else begin
			off_n = off_w;
			p_n   = p_w;
		end
		// clamp the offset to its 48-bit range
		if (off_n > OFF_HI)
			off_c = OFF_HI[OFF_BITS-1:0];
		else if (off_n < OFF_LO)
			off_c = OFF_LO[OFF_BITS-1:0];
		else
			off_c = off_n[OFF_BITS-1:0];
		// clamp the point to the coordinate range
		sat = 1'b1;
		if (p_n > C_HI)
			result = C_HI[COORD_BITS-1:0];
		else if (p_n < C_LO)
			result = C_LO[COORD_BITS-1:0];
		else begin
			result = p_n[COORD_BITS-1:0];
			sat    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			prev_q <= '0;
		end else if (ctl.fire) begin
			off_q  <= off_c;
			prev_q <= result;
		end
	end

endmodule

>>> sv/ppu_merge.sv
// Merge stage: gathers the lane results into the output register.
`timescale 1ns / 1ps

module ppu_merge import ppu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic signed [COORD_BITS-1:0] lane_x,
	input  logic signed [COORD_BITS-1:0] lane_y,
	input  logic signed [COORD_BITS-1:0] lane_z,
	input  logic [NUM_AXES-1:0]          lane_sat,
	output logic                         accept_ok,
	ppu_out_if.source                    out_ch
);

	logic                         valid_q;
	logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
	logic                         sat_q;

	// take a new result while empty or while the held one leaves
	assign accept_ok = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (fire)
			valid_q <= 1'b1;
		else if (out_ch.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			x_q   <= lane_x;
			y_q   <= lane_y;
			z_q   <= lane_z;
			sat_q <= |lane_sat;
		end
	end

	assign out_ch.valid       = valid_q;
	assign out_ch.unwrapped_x = x_q;
	assign out_ch.unwrapped_y = y_q;
	assign out_ch.unwrapped_z = z_q;
	assign out_ch.saturated   = sat_q;

endmodule

>>> sv/periodic_polyline_unwrap_top.sv
// A transferred point appears on the output register in the next cycle.
// Throughput: one point per cycle while the output register is empty or being taken;
//   each lane computes its next offset and previous point combinationally from the held ones.
// Reset (arst_n low, asynchronous): offsets, previous points and line state clear,
//   periods return to 1.0 (65536), the output register empties.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module periodic_polyline_unwrap_top import ppu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	ppu_in_if.sink                  in_ch,
	ppu_out_if.source               out_ch,
	input  logic                    wr_en,
	input  logic [REG_IDX_BITS-1:0] wr_index,
	input  logic [PERIOD_BITS-1:0]  wr_data
);

	// Period registers, one per axis.
	logic [PERIOD_BITS-1:0] period_q [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++)
				period_q[i] <= PERIOD_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_PERIOD_X: period_q[0] <= wr_data;
				REG_PERIOD_Y: period_q[1] <= wr_data;
				REG_PERIOD_Z: period_q[2] <= wr_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// Handshake: ready follows the output register, so a result that waits
	// does not block the next transfer once it is taken.
	logic      accept_ok;
	logic      in_fire;
	logic      have_prev_q;
	lane_ctl_t ctl;

	assign in_ch.ready = accept_ok;
	assign in_fire     = in_ch.valid && accept_ok;

	assign ctl.fire      = in_fire;
	assign ctl.start     = in_ch.line_start;
	assign ctl.have_prev = have_prev_q;

	// Set once a point of the line has left; a line start re-arms it at once
	// because that point itself becomes the previous one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			have_prev_q <= 1'b0;
		else if (in_fire)
			have_prev_q <= 1'b1;
	end

	// Lanes: one copy of the unwrap core per axis.
	logic signed [COORD_BITS-1:0] lane_in  [NUM_AXES];
	logic signed [COORD_BITS-1:0] lane_out [NUM_AXES];
	logic [NUM_AXES-1:0]          lane_sat;

	assign lane_in[0] = in_ch.coord_x;
	assign lane_in[1] = in_ch.coord_y;
	assign lane_in[2] = in_ch.coord_z;

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		ppu_lane #(
			.COORD_BITS (COORD_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.coord  (lane_in[a]),
			.period (period_q[a]),
			.result (lane_out[a]),
			.sat    (lane_sat[a])
		);
	end

	// Merge: combine the lane results and hold them for the sink.
	ppu_merge #(
		.COORD_BITS (COORD_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (in_fire),
		.lane_x    (lane_out[0]),
		.lane_y    (lane_out[1]),
		.lane_z    (lane_out[2]),
		.lane_sat  (lane_sat),
		.accept_ok (accept_ok),
		.out_ch    (out_ch)
	);

	`ASSERT_NEXT(a_fire_fills_out, in_fire, out_ch.valid, "transfer left no result")
	`ASSERT_CLK(a_empty_takes, !out_ch.valid |-> in_ch.ready, "empty output but input stalled")
	`ASSERT_NEXT(a_prev_only_on_fire, !in_fire, $stable(have_prev_q), "line state moved idle")
	`ASSERT_NEXT(a_period_x_write, wr_en && (wr_index == REG_PERIOD_X), period_q[0] == $past(wr_data), "period x not written")

endmodule

>>> bench/testbench.sv
// Testbench for the periodic polyline unwrap block: directed table, random walks, self-checked.
`timescale 1ns / 1ps

module testbench;
	import ppu_pkg::*;

	localparam int CB = COORD_BITS_DEF;

	// Index that decodes to no register; writes to it must leave every period alone.
	localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	// Give up after this many cycles with no transfer on either channel.
	localparam int STALL_LIMIT = 2000;

	// Random part: segments of points, each opened with a fresh set of periods.
	localparam int RAND_SEGMENTS = 31;
	localparam int SEG_ITEMS     = 50;

	localparam logic signed [CB-1:0] CMAX = 32'sh7FFF_FFFF;
	localparam logic signed [CB-1:0] CMIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
		logic                 start;
	} point_t;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
		logic                 sat;
	} result_t;

	typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [REG_IDX_BITS-1:0] reg_idx;
		logic [PERIOD_BITS-1:0]  reg_val;
		point_t                  pt;
		logic                    typed;   // res below holds the expected result
		result_t                 res;
	} stim_row_t;

	localparam point_t  NO_PT  = '0;
	localparam result_t NO_RES = '0;

	localparam int DIR_ROWS = 25;

	// Directed table. Rows with typed set carry a result that follows straight from the
	// behaviour: a line start passes the point through, a jump of exactly half a period
	// is left alone, one just over half a period is pulled back by a period.
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		// periods at their reset value of 1.0
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMAX, CMIN, 32'sh0, 1'b1},
			1'b1, '{CMAX, CMIN, 32'sh0, 1'b0}},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMAX, CMIN, 32'sh0000_8000, 1'b0},
			1'b1, '{CMAX, CMIN, 32'sh0000_8000, 1'b0}},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMAX, CMIN, 32'sh0001_0001, 1'b0},
			1'b1, '{CMAX, CMIN, 32'sh0000_0001, 1'b0}},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMAX, CMIN, 32'sh0, 1'b0}, 1'b0, NO_RES},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{32'sh0, 32'sh0, 32'sh0, 1'b1},
			1'b1, '{32'sh0, 32'sh0, 32'sh0, 1'b0}},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{32'shFFFF_8000, 32'sh0001_0000, 32'sh0, 1'b0},
			1'b1, '{32'shFFFF_8000, 32'sh0, 32'sh0, 1'b0}},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMIN, CMAX, 32'sh0001_0000, 1'b0}, 1'b0, NO_RES},
		// widest period on x, narrowest on y, zero on z
		'{ROW_WRITE, REG_PERIOD_X, 31'h7FFF_FFFF, NO_PT, 1'b0, NO_RES},
		'{ROW_WRITE, REG_PERIOD_Y, 31'd1, NO_PT, 1'b0, NO_RES},
		'{ROW_WRITE, REG_PERIOD_Z, 31'd0, NO_PT, 1'b0, NO_RES},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMAX, 32'sh0, CMAX, 1'b1},
			1'b1, '{CMAX, 32'sh0, CMAX, 1'b0}},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{32'sh0, 32'sh1, CMIN, 1'b0}, 1'b0, NO_RES},
		// x runs past the top of the range and clamps
		'{ROW_POINT, REG_UNUSED, 31'd0, '{32'sh3FFF_FFFF, CMIN, 32'sh0, 1'b0}, 1'b0, NO_RES},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMIN, CMAX, 32'sh0, 1'b1},
			1'b1, '{CMIN, CMAX, 32'sh0, 1'b0}},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{32'sh0, 32'sh0, -32'sh1, 1'b0}, 1'b0, NO_RES},
		// x runs past the bottom of the range and clamps
		'{ROW_POINT, REG_UNUSED, 31'd0, '{32'shC000_0001, CMIN, 32'sh0001_0000, 1'b0},
			1'b0, NO_RES},
		// a write to an unmapped index must not disturb the widest x period
		'{ROW_WRITE, REG_UNUSED, 31'd0, NO_PT, 1'b0, NO_RES},
		'{ROW_WRITE, REG_PERIOD_Z, PERIOD_RESET, NO_PT, 1'b0, NO_RES},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1},
			1'b1, '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0}},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{32'sh7FFF_0000, 32'sh2, 32'sh0000_9000, 1'b0},
			1'b0, NO_RES},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMIN, -32'sh2, 32'shFFFF_0000, 1'b0}, 1'b0, NO_RES},
		'{ROW_WRITE, REG_PERIOD_X, PERIOD_RESET, NO_PT, 1'b0, NO_RES},
		'{ROW_WRITE, REG_PERIOD_Y, 31'h7FFF_FFFF, NO_PT, 1'b0, NO_RES},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMAX, CMIN, 32'sh0, 1'b0}, 1'b0, NO_RES},
		'{ROW_POINT, REG_UNUSED, 31'd0, '{CMIN, CMAX, 32'sh0000_8000, 1'b0}, 1'b0, NO_RES}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    wr_en;
	logic [REG_IDX_BITS-1:0] wr_index;
	logic [PERIOD_BITS-1:0]  wr_data;

	ppu_in_if  #(.COORD_BITS(CB)) in_ch ();
	ppu_out_if #(.COORD_BITS(CB)) out_ch ();

	periodic_polyline_unwrap_top #(.COORD_BITS(CB)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Shadow of the block: periods, per-axis wrap offsets, last emitted point.
	logic [PERIOD_BITS-1:0] period_cfg [NUM_AXES];
	longint                 wrap_off   [NUM_AXES];
	longint                 last_pt    [NUM_AXES];
	bit                     line_open;

	// Unwrapped points still owed by the block, oldest first.
	result_t pending_results [$];

	// True (unwrapped) position of the random walk on each axis.
	longint walk_pos [NUM_AXES];

	int src_idle_pct;
	int snk_idle_pct;
	int mismatches;
	int quiet_cycles;

	always #5 clk = ~clk;

	function automatic longint clamp_signed(input longint v, input int bits, inout bit hit);
		longint hi;
		hi = (longint'(1) << (bits - 1)) - 1;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			hit = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	// Unwrap one point against the shadow state and advance that state.
	function automatic result_t unwrap_predict(input point_t pt);
		result_t res;
		longint  c [NUM_AXES];
		longint  per, p, d2;
		bit      hit, off_hit;
		c[0]    = longint'(pt.x);
		c[1]    = longint'(pt.y);
		c[2]    = longint'(pt.z);
		hit     = 1'b0;
		off_hit = 1'b0;
		if (pt.start) begin
			foreach (wrap_off[j])
				wrap_off[j] = 0;
			line_open = 1'b0;
		end
		for (int j = 0; j < NUM_AXES; j++) begin
			per = longint'(period_cfg[j]);
			p   = c[j] + wrap_off[j];
			// pull back by one period when the step exceeds half a period, strictly
			if (line_open) begin
				d2 = (p - last_pt[j]) * 2;
				if (d2 > per) begin
					wrap_off[j] = clamp_signed(wrap_off[j] - per, OFF_BITS, off_hit);
					p -= per;
				end else if (d2 < -per) begin
					wrap_off[j] = clamp_signed(wrap_off[j] + per, OFF_BITS, off_hit);
					p += per;
				end
			end
			// the clamped value is what later steps compare against
			p          = clamp_signed(p, CB, hit);
			last_pt[j] = p;
			c[j]       = p;
		end
		line_open = 1'b1;
		res.x     = c[0][CB-1:0];
		res.y     = c[1][CB-1:0];
		res.z     = c[2][CB-1:0];
		res.sat   = hit;
		return res;
	endfunction

	// Next wrapped coordinate of a random polyline. Most steps stay within half a period
	// so the block sees genuine wrap crossings; some land exactly on or just past half a
	// period, and a few are extremes or pure noise.
	function automatic logic signed [CB-1:0] next_coord(input int ax, input bit fresh);
		longint per, stp, w;
		per = longint'(period_cfg[ax]);
		if (fresh)
			walk_pos[ax] = longint'($signed($urandom()));
		case ($urandom_range(0, 19))
			0: return CMAX;
			1: return CMIN;
			2, 3: return $urandom();
			default: ;
		endcase
		// a period of zero or one: wander in tiny steps
		if (per < 2) begin
			walk_pos[ax] += longint'($urandom_range(0, 4)) - 2;
			return walk_pos[ax][CB-1:0];
		end
		case ($urandom_range(0, 5))
			0: stp = per / 2;
			1: stp = per / 2 + 1;
			default: stp = longint'($urandom_range(0, 32'(per / 2)));
		endcase
		if ($urandom_range(0, 1) == 1)
			stp = -stp;
		walk_pos[ax] += stp;
		w = walk_pos[ax] % per;
		if (w < 0)
			w += per;
		// fold into the negative half now and then
		if ($urandom_range(0, 3) == 0)
			w -= per;
		return w[CB-1:0];
	endfunction

	function automatic logic [PERIOD_BITS-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: return 31'd1;
			1: return '1;
			2: return 31'd0;
			3: return PERIOD_RESET;
			4, 5: return PERIOD_BITS'($urandom());
			default: return PERIOD_BITS'($urandom_range(16, 32'h0004_0000));
		endcase
	endfunction

	// Drop valid and wait until every owed result has been taken, plus the output stage.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write one register while the block is idle; mirror it in the shadow copy.
	task automatic write_period(input logic [REG_IDX_BITS-1:0] idx,
			input logic [PERIOD_BITS-1:0] val);
		drain();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx < NUM_AXES)
			period_cfg[idx] = val;
		@(posedge clk);
	endtask

	// Offer one point, hold it until the transfer, then queue what it must produce.
	task automatic send_point(input point_t pt, input bit typed, input result_t typed_res);
		result_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.coord_x    <= pt.x;
		in_ch.coord_y    <= pt.y;
		in_ch.coord_z    <= pt.z;
		in_ch.line_start <= pt.start;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		// advance the shadow state even where the row supplies the result
		predicted = unwrap_predict(pt);
		pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
	endtask

	task automatic flag_mismatch(input string field, input logic [CB-1:0] want_v,
			input logic [CB-1:0] got_v);
		$display("%0t ns: %s expected %h, got %h", $time, field, want_v, got_v);
		mismatches++;
	endtask

	// Receiver: stall at random according to the current idle share.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// Check every output transfer against the oldest owed result.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.unwrapped_x, out_ch.unwrapped_y, out_ch.unwrapped_z,
				out_ch.saturated};
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result x=%h y=%h z=%h sat=%b", $time,
					got.x, got.y, got.z, got.sat);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.x !== want.x)
					flag_mismatch("unwrapped_x", want.x, got.x);
				if (got.y !== want.y)
					flag_mismatch("unwrapped_y", want.y, got.y);
				if (got.z !== want.z)
					flag_mismatch("unwrapped_z", want.z, got.z);
				if (got.sat !== want.sat)
					flag_mismatch("saturated", CB'(want.sat), CB'(got.sat));
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves anything.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		point_t pt;

		// Initialise every input and the shadow state to its reset value.
		clk              = 1'b0;
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = '0;
		wr_data          = '0;
		in_ch.valid      = 1'b0;
		in_ch.coord_x    = '0;
		in_ch.coord_y    = '0;
		in_ch.coord_z    = '0;
		in_ch.line_start = 1'b0;
		out_ch.ready     = 1'b0;
		mismatches       = 0;
		quiet_cycles     = 0;
		line_open        = 1'b0;
		foreach (period_cfg[j]) begin
			period_cfg[j] = PERIOD_RESET;
			wrap_off[j]   = 0;
			last_pt[j]    = 0;
			walk_pos[j]   = 0;
		end

		// Directed part runs with a lazy sender and a fussy receiver.
		src_idle_pct = 14;
		snk_idle_pct = 45;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; the first rows rely on the reset periods.
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIR_TABLE[r].kind == ROW_WRITE)
				write_period(DIR_TABLE[r].reg_idx, DIR_TABLE[r].reg_val);
			else
				send_point(DIR_TABLE[r].pt, DIR_TABLE[r].typed, DIR_TABLE[r].res);
		end

		// Random polylines: swap the idle shares after a third, then run flat out.
		for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
			if (seg == RAND_SEGMENTS / 3) begin
				src_idle_pct = 45;
				snk_idle_pct = 14;
			end else if (seg == 2 * RAND_SEGMENTS / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			for (int a = 0; a < NUM_AXES; a++)
				write_period(REG_IDX_BITS'(a), pick_period());
			if ($urandom_range(0, 3) == 0)
				write_period(REG_UNUSED, PERIOD_BITS'($urandom()));
			for (int k = 0; k < SEG_ITEMS; k++) begin
				// every other segment carries its line on across the period change
				pt.start = ($urandom_range(0, 24) == 0) || (k == 0 && seg % 2 == 0);
				pt.x     = next_coord(0, pt.start);
				pt.y     = next_coord(1, pt.start);
				pt.z     = next_coord(2, pt.start);
				send_point(pt, 1'b0, NO_RES);
			end
		end

		// Wait for the last results, then watch the output stage for any stray result.
		drain();
		repeat (4) @(posedge clk);

		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
